@@ hw/rtl/pgv_pkg.sv @@
// pgv_pkg: widths, register indexes and pipeline word types of the pairwise gravity block
// no dependencies; imported by every module of the block
package pgv_pkg;

    localparam int DATA_W    = 32;
    localparam int STEP_W    = 16;
    localparam int CFG_IDX_W = 4;
    localparam int ROOT_W    = 34;
    localparam int DSQ_W     = 66;
    localparam int TRIAL_W   = 2 * ROOT_W;
    localparam int NUM_W     = 112;
    localparam int DEN_W     = 3 * ROOT_W;
    localparam int Q_W       = DATA_W + 1;
    localparam int CMP_W     = DEN_W + Q_W - 1;
    localparam int SUM_W     = DATA_W + 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRAV_CONST = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP  = CFG_IDX_W'(1);

    localparam logic [DATA_W-1:0] GRAV_RESET = 32'd65536;
    localparam logic [STEP_W-1:0] STEP_RESET = 16'd1092;

    localparam logic [DATA_W-1:0] VEL_MAX = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] VEL_MIN = 32'h8000_0000;

    // fields that ride alongside the distance and division work
    typedef struct packed {
        logic signed [DATA_W-1:0] vel_x;
        logic signed [DATA_W-1:0] vel_y;
        logic                     neg_x;
        logic                     neg_y;
        logic                     coinc;
        logic [NUM_W-1:0]         num_x;
        logic [NUM_W-1:0]         num_y;
    } pgv_side_t;

    typedef struct packed {
        pgv_side_t          side;
        logic [DSQ_W-1:0]   dsq;
    } pgv_front_t;

    typedef struct packed {
        pgv_side_t          side;
        logic [ROOT_W-1:0]  root;
    } pgv_root_t;

    typedef struct packed {
        pgv_side_t          side;
        logic [DEN_W-1:0]   den;
    } pgv_den_t;

    typedef struct packed {
        pgv_side_t          side;
        logic [Q_W-1:0]     q_x;
        logic [Q_W-1:0]     q_y;
    } pgv_quot_t;

endpackage

@@ hw/rtl/pgv_front.sv @@
// pgv_front: six stages for differences, squares, squared distance and pull numerators
// depends on pgv_pkg
module pgv_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic                                in_valid,
    input  logic signed [pgv_pkg::DATA_W-1:0]   self_pos_x,
    input  logic signed [pgv_pkg::DATA_W-1:0]   self_pos_y,
    input  logic signed [pgv_pkg::DATA_W-1:0]   self_vel_x,
    input  logic signed [pgv_pkg::DATA_W-1:0]   self_vel_y,
    input  logic signed [pgv_pkg::DATA_W-1:0]   other_pos_x,
    input  logic signed [pgv_pkg::DATA_W-1:0]   other_pos_y,
    input  logic        [pgv_pkg::DATA_W-1:0]   other_mass,
    input  logic        [pgv_pkg::DATA_W-1:0]   grav_const,
    input  logic        [pgv_pkg::STEP_W-1:0]   time_step,
    output logic                                out_valid,
    output pgv_pkg::pgv_front_t                 out_word
);
    import pgv_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;

    logic [DATA_W:0]          dx1_reg, dy1_reg, dx1_next, dy1_next;
    logic [DATA_W-1:0]        mass1_reg, mass2_reg;
    logic signed [DATA_W-1:0] vx1_reg, vy1_reg, vx2_reg, vy2_reg, vx3_reg, vy3_reg;
    logic signed [DATA_W-1:0] vx4_reg, vy4_reg, vx5_reg, vy5_reg, vx6_reg, vy6_reg;
    logic [DATA_W:0]          adx, ady;
    logic [DATA_W-1:0]        ax2_reg, ay2_reg, ax3_reg, ay3_reg, ax4_reg, ay4_reg;
    logic                     nx2_reg, ny2_reg, nx3_reg, ny3_reg, nx4_reg, ny4_reg;
    logic                     nx5_reg, ny5_reg, nx6_reg, ny6_reg;
    logic                     c3_reg, c4_reg, c5_reg, c6_reg;
    logic [2*DATA_W-1:0]      sqx3_reg, sqy3_reg, gm3_reg;
    logic [DSQ_W-1:0]         dsq4_reg, dsq5_reg, dsq6_reg;
    logic [2*DATA_W+STEP_W-1:0] gmt4_reg;
    logic [71:0]              plx5_reg, phx5_reg, ply5_reg, phy5_reg;
    logic [NUM_W-1:0]         numx6_reg, numy6_reg;

    // coordinate differences, exact at one bit over the field width
    assign dx1_next = {other_pos_x[DATA_W-1], other_pos_x} - {self_pos_x[DATA_W-1], self_pos_x};
    assign dy1_next = {other_pos_y[DATA_W-1], other_pos_y} - {self_pos_y[DATA_W-1], self_pos_y};

    // magnitudes of the differences
    assign adx = dx1_reg[DATA_W] ? ((DATA_W+1)'(0) - dx1_reg) : dx1_reg;
    assign ady = dy1_reg[DATA_W] ? ((DATA_W+1)'(0) - dy1_reg) : dy1_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage 1: differences
            dx1_reg   <= dx1_next;
            dy1_reg   <= dy1_next;
            vx1_reg   <= self_vel_x;
            vy1_reg   <= self_vel_y;
            mass1_reg <= other_mass;
            // stage 2: magnitudes and directions
            ax2_reg   <= adx[DATA_W-1:0];
            ay2_reg   <= ady[DATA_W-1:0];
            nx2_reg   <= dx1_reg[DATA_W];
            ny2_reg   <= dy1_reg[DATA_W];
            vx2_reg   <= vx1_reg;
            vy2_reg   <= vy1_reg;
            mass2_reg <= mass1_reg;
            // stage 3: squares and constant times mass
            sqx3_reg  <= ax2_reg * ax2_reg;
            sqy3_reg  <= ay2_reg * ay2_reg;
            gm3_reg   <= grav_const * mass2_reg;
            c3_reg    <= (ax2_reg == '0) && (ay2_reg == '0);
            ax3_reg   <= ax2_reg;
            ay3_reg   <= ay2_reg;
            nx3_reg   <= nx2_reg;
            ny3_reg   <= ny2_reg;
            vx3_reg   <= vx2_reg;
            vy3_reg   <= vy2_reg;
            // stage 4: squared distance and time step product
            dsq4_reg  <= {2'b00, sqx3_reg} + {2'b00, sqy3_reg};
            gmt4_reg  <= gm3_reg * time_step;
            c4_reg    <= c3_reg;
            ax4_reg   <= ax3_reg;
            ay4_reg   <= ay3_reg;
            nx4_reg   <= nx3_reg;
            ny4_reg   <= ny3_reg;
            vx4_reg   <= vx3_reg;
            vy4_reg   <= vy3_reg;
            // stage 5: partial products of the numerators
            plx5_reg  <= gmt4_reg[39:0] * ax4_reg;
            phx5_reg  <= gmt4_reg[79:40] * ax4_reg;
            ply5_reg  <= gmt4_reg[39:0] * ay4_reg;
            phy5_reg  <= gmt4_reg[79:40] * ay4_reg;
            dsq5_reg  <= dsq4_reg;
            c5_reg    <= c4_reg;
            nx5_reg   <= nx4_reg;
            ny5_reg   <= ny4_reg;
            vx5_reg   <= vx4_reg;
            vy5_reg   <= vy4_reg;
            // stage 6: numerators
            numx6_reg <= {40'd0, plx5_reg} + {phx5_reg, 40'd0};
            numy6_reg <= {40'd0, ply5_reg} + {phy5_reg, 40'd0};
            dsq6_reg  <= dsq5_reg;
            c6_reg    <= c5_reg;
            nx6_reg   <= nx5_reg;
            ny6_reg   <= ny5_reg;
            vx6_reg   <= vx5_reg;
            vy6_reg   <= vy5_reg;
        end
    end

    assign out_valid           = v6_reg;
    assign out_word.side.vel_x = vx6_reg;
    assign out_word.side.vel_y = vy6_reg;
    assign out_word.side.neg_x = nx6_reg;
    assign out_word.side.neg_y = ny6_reg;
    assign out_word.side.coinc = c6_reg;
    assign out_word.side.num_x = numx6_reg;
    assign out_word.side.num_y = numy6_reg;
    assign out_word.dsq        = dsq6_reg;

endmodule

@@ hw/rtl/pgv_sqrt.sv @@
// pgv_sqrt: integer square root of the squared distance, one root bit per stage
// depends on pgv_pkg
module pgv_sqrt (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  in_valid,
    input  pgv_pkg::pgv_front_t   in_word,
    output logic                  out_valid,
    output pgv_pkg::pgv_root_t    out_word
);
    import pgv_pkg::*;

    typedef struct packed {
        pgv_side_t          side;
        logic [DSQ_W-1:0]   rem;
        logic [ROOT_W-1:0]  root;
    } sq_stage_t;

    sq_stage_t stage_reg [ROOT_W];
    sq_stage_t stage_in  [ROOT_W];
    logic      vld_reg   [ROOT_W];
    logic      vld_in    [ROOT_W];

    assign stage_in[0].side = in_word.side;
    assign stage_in[0].rem  = in_word.dsq;
    assign stage_in[0].root = '0;
    assign vld_in[0]        = in_valid;

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_stage
        localparam int BIT = ROOT_W - 1 - k;
        logic [TRIAL_W-1:0] trial;
        sq_stage_t          stage_next;

        if (k > 0)
        begin : g_link
            assign stage_in[k] = stage_reg[k-1];
            assign vld_in[k]   = vld_reg[k-1];
        end

        // try setting this root bit: remainder must cover 2*root*2^bit + 4^bit
        always_comb
        begin
            trial = (TRIAL_W'(stage_in[k].root) << (BIT + 1)) | (TRIAL_W'(1) << (2 * BIT));
            stage_next = stage_in[k];
            if (TRIAL_W'(stage_in[k].rem) >= trial)
            begin
                stage_next.rem       = stage_in[k].rem - trial[DSQ_W-1:0];
                stage_next.root[BIT] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (adv)
                vld_reg[k] <= vld_in[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                stage_reg[k] <= stage_next;
        end
    end

    assign out_valid     = vld_reg[ROOT_W-1];
    assign out_word.side = stage_reg[ROOT_W-1].side;
    assign out_word.root = stage_reg[ROOT_W-1].root;

endmodule

@@ hw/rtl/pgv_cube.sv @@
// pgv_cube: cube of the distance over three stages of bounded multipliers
// depends on pgv_pkg
module pgv_cube (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  in_valid,
    input  pgv_pkg::pgv_root_t    in_word,
    output logic                  out_valid,
    output pgv_pkg::pgv_den_t     out_word
);
    import pgv_pkg::*;

    logic              v1_reg, v2_reg, v3_reg;
    pgv_side_t         side1_reg, side2_reg, side3_reg;
    logic [ROOT_W-1:0] root1_reg;
    logic [TRIAL_W-1:0] sq1_reg, plo2_reg, phi2_reg;
    logic [DEN_W-1:0]  den3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // square of the root
            sq1_reg   <= in_word.root * in_word.root;
            root1_reg <= in_word.root;
            side1_reg <= in_word.side;
            // square split in halves, each times the root
            plo2_reg  <= sq1_reg[ROOT_W-1:0] * root1_reg;
            phi2_reg  <= sq1_reg[TRIAL_W-1:ROOT_W] * root1_reg;
            side2_reg <= side1_reg;
            // recombine
            den3_reg  <= {(DEN_W-TRIAL_W)'(0), plo2_reg} + {phi2_reg, (DEN_W-TRIAL_W)'(0)};
            side3_reg <= side2_reg;
        end
    end

    assign out_valid     = v3_reg;
    assign out_word.side = side3_reg;
    assign out_word.den  = den3_reg;

endmodule

@@ hw/rtl/pgv_div.sv @@
// pgv_div: restoring division of both numerators by the cubed distance, one quotient bit per stage
// depends on pgv_pkg; the top quotient bit marks a pull of 2^32 or more
module pgv_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  in_valid,
    input  pgv_pkg::pgv_den_t     in_word,
    output logic                  out_valid,
    output pgv_pkg::pgv_quot_t    out_word
);
    import pgv_pkg::*;

    typedef struct packed {
        pgv_side_t          side;
        logic [DEN_W-1:0]   den;
        logic [NUM_W-1:0]   rem_x;
        logic [NUM_W-1:0]   rem_y;
        logic [Q_W-1:0]     q_x;
        logic [Q_W-1:0]     q_y;
    } dv_stage_t;

    dv_stage_t stage_reg [Q_W];
    dv_stage_t stage_in  [Q_W];
    logic      vld_reg   [Q_W];
    logic      vld_in    [Q_W];

    assign stage_in[0].side  = in_word.side;
    assign stage_in[0].den   = in_word.den;
    assign stage_in[0].rem_x = in_word.side.num_x;
    assign stage_in[0].rem_y = in_word.side.num_y;
    assign stage_in[0].q_x   = '0;
    assign stage_in[0].q_y   = '0;
    assign vld_in[0]         = in_valid;

    for (genvar k = 0; k < Q_W; k++)
    begin : g_stage
        localparam int BIT = Q_W - 1 - k;
        logic [CMP_W-1:0] dsh;
        dv_stage_t        stage_next;

        if (k > 0)
        begin : g_link
            assign stage_in[k] = stage_reg[k-1];
            assign vld_in[k]   = vld_reg[k-1];
        end

        // compare each remainder with the shifted divisor
        always_comb
        begin
            dsh = CMP_W'(stage_in[k].den) << BIT;
            stage_next = stage_in[k];
            if (CMP_W'(stage_in[k].rem_x) >= dsh)
            begin
                stage_next.rem_x    = stage_in[k].rem_x - dsh[NUM_W-1:0];
                stage_next.q_x[BIT] = 1'b1;
            end
            if (CMP_W'(stage_in[k].rem_y) >= dsh)
            begin
                stage_next.rem_y    = stage_in[k].rem_y - dsh[NUM_W-1:0];
                stage_next.q_y[BIT] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (adv)
                vld_reg[k] <= vld_in[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                stage_reg[k] <= stage_next;
        end
    end

    assign out_valid     = vld_reg[Q_W-1];
    assign out_word.side = stage_reg[Q_W-1].side;
    assign out_word.q_x  = stage_reg[Q_W-1].q_x;
    assign out_word.q_y  = stage_reg[Q_W-1].q_y;

endmodule

@@ hw/rtl/pairwise_gravity_velocity_update.sv @@
// pairwise_gravity_velocity_update: top level, configuration registers and output stage
// depends on pgv_pkg, pgv_front, pgv_sqrt, pgv_cube, pgv_div
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+--------------------------------------------
//  in      | in        | in_valid/in_stall  | positions, velocity, mass of one body pair
//  out     | out       | out_valid/out_stall| new velocity, coincident, saturated
//  cfg     | in        | cfg_valid/cfg_ready| register index and data
//
// one pair is accepted every cycle while in_stall is low; the path runs through 6 front stages,
// 34 square root stages (one root bit each), 3 cube stages, 33 divider stages
// (one quotient bit each) and the output register.
// reset clears all valid bits and loads the register defaults; no clearing pass.
// a stalled result freezes the whole pipeline in place; the input is stalled
// only while a result sits in the output register and is not taken.
module pairwise_gravity_velocity_update (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [pgv_pkg::DATA_W-1:0]   self_pos_x,
    input  logic signed [pgv_pkg::DATA_W-1:0]   self_pos_y,
    input  logic signed [pgv_pkg::DATA_W-1:0]   self_vel_x,
    input  logic signed [pgv_pkg::DATA_W-1:0]   self_vel_y,
    input  logic signed [pgv_pkg::DATA_W-1:0]   other_pos_x,
    input  logic signed [pgv_pkg::DATA_W-1:0]   other_pos_y,
    input  logic        [pgv_pkg::DATA_W-1:0]   other_mass,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [pgv_pkg::DATA_W-1:0]   new_vel_x,
    output logic signed [pgv_pkg::DATA_W-1:0]   new_vel_y,
    output logic                                coincident,
    output logic                                saturated,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic        [pgv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [pgv_pkg::DATA_W-1:0]   cfg_data
);
    import pgv_pkg::*;

    logic [DATA_W-1:0] grav_reg;
    logic [STEP_W-1:0] step_reg;
    logic              adv;

    logic       front_v, root_v, den_v, quot_v;
    pgv_front_t front_w;
    pgv_root_t  root_w;
    pgv_den_t   den_w;
    pgv_quot_t  quot_w;

    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] vel_x_reg, vel_y_reg, vel_x_next, vel_y_next;
    logic                     coinc_reg, sat_reg, sat_next;
    logic [Q_W-1:0]           mag_x, mag_y;
    logic [SUM_W-1:0]         sum_x, sum_y;
    logic                     sat_x, sat_y;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grav_reg <= GRAV_RESET;
            step_reg <= STEP_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_GRAV_CONST: grav_reg <= cfg_data;
                REG_TIME_STEP:  step_reg <= cfg_data[STEP_W-1:0];
                default:        ;
            endcase
        end
    end

    // whole pipeline moves unless the output word is held
    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    pgv_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_valid    (in_valid),
        .self_pos_x  (self_pos_x),
        .self_pos_y  (self_pos_y),
        .self_vel_x  (self_vel_x),
        .self_vel_y  (self_vel_y),
        .other_pos_x (other_pos_x),
        .other_pos_y (other_pos_y),
        .other_mass  (other_mass),
        .grav_const  (grav_reg),
        .time_step   (step_reg),
        .out_valid   (front_v),
        .out_word    (front_w)
    );

    pgv_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (front_v),
        .in_word   (front_w),
        .out_valid (root_v),
        .out_word  (root_w)
    );

    pgv_cube u_cube (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (root_v),
        .in_word   (root_w),
        .out_valid (den_v),
        .out_word  (den_w)
    );

    pgv_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (den_v),
        .in_word   (den_w),
        .out_valid (quot_v),
        .out_word  (quot_w)
    );

    // clamp the pull to 2^32, apply it and saturate; a coincident pair keeps its velocity
    always_comb
    begin
        mag_x = quot_w.q_x[Q_W-1] ? {1'b1, (Q_W-1)'(0)} : quot_w.q_x;
        mag_y = quot_w.q_y[Q_W-1] ? {1'b1, (Q_W-1)'(0)} : quot_w.q_y;
        sum_x = quot_w.side.neg_x
              ? ({{2{quot_w.side.vel_x[DATA_W-1]}}, quot_w.side.vel_x} - {1'b0, mag_x})
              : ({{2{quot_w.side.vel_x[DATA_W-1]}}, quot_w.side.vel_x} + {1'b0, mag_x});
        sum_y = quot_w.side.neg_y
              ? ({{2{quot_w.side.vel_y[DATA_W-1]}}, quot_w.side.vel_y} - {1'b0, mag_y})
              : ({{2{quot_w.side.vel_y[DATA_W-1]}}, quot_w.side.vel_y} + {1'b0, mag_y});
        sat_x = (sum_x[SUM_W-1:DATA_W-1] != 3'b000) && (sum_x[SUM_W-1:DATA_W-1] != 3'b111);
        sat_y = (sum_y[SUM_W-1:DATA_W-1] != 3'b000) && (sum_y[SUM_W-1:DATA_W-1] != 3'b111);
        if (quot_w.side.coinc)
        begin
            vel_x_next = quot_w.side.vel_x;
            vel_y_next = quot_w.side.vel_y;
            sat_next   = 1'b0;
        end
        else
        begin
            vel_x_next = sat_x ? (sum_x[SUM_W-1] ? VEL_MIN : VEL_MAX) : sum_x[DATA_W-1:0];
            vel_y_next = sat_y ? (sum_y[SUM_W-1] ? VEL_MIN : VEL_MAX) : sum_y[DATA_W-1:0];
            sat_next   = sat_x || sat_y;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= quot_v;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vel_x_reg <= vel_x_next;
            vel_y_reg <= vel_y_next;
            coinc_reg <= quot_w.side.coinc;
            sat_reg   <= sat_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign new_vel_x  = vel_x_reg;
    assign new_vel_y  = vel_y_reg;
    assign coincident = coinc_reg;
    assign saturated  = sat_reg;

    // checks
    a_coinc_not_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && coincident) |-> !saturated)
        else $error("coincident word flagged as saturated");

    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |->
        (new_vel_x == VEL_MAX || new_vel_x == VEL_MIN ||
         new_vel_y == VEL_MAX || new_vel_y == VEL_MIN))
        else $error("saturated word has no component at a limit");

    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no word waiting at the output");

endmodule
